// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define FSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsr assertion failed");

// checked at every edge, reset included
`define FSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsr assertion failed");

`endif

// File: rtl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// shared types and constants of the byte stuffed frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package fsr_pkg;

  localparam int unsigned FRAME_CAPACITY_DEF = 128;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned LEN_W  = 8;

  localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h7D;
  localparam logic [BYTE_W-1:0] BYTE_START  = 8'h7E;
  localparam logic [BYTE_W-1:0] BYTE_END    = 8'h7F;
  localparam logic [BYTE_W-1:0] ESCAPE_XOR  = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_IN   = 2'd1,
    PH_ESC  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE = 2'd0,
    CMD_READ = 2'd1,
    CMD_DROP = 2'd2
  } cmd_e;

  // per word result known at accept time, read data follows from the store
  typedef struct packed {
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic              hit;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/fsr_store.sv
// ----------------------------------------------------------------------------
// fsr_store
// frame store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_store #(
  parameter int unsigned FRAME_CAPACITY = fsr_pkg::FRAME_CAPACITY_DEF,
  localparam int unsigned AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [fsr_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [fsr_pkg::BYTE_W-1:0] rdata_o
);
  import fsr_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_CAPACITY];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fsr_ctrl.sv
// ----------------------------------------------------------------------------
// fsr_ctrl
// deframing phase, byte count and store access for each accepted word
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_ctrl #(
  parameter int unsigned FRAME_CAPACITY = fsr_pkg::FRAME_CAPACITY_DEF,
  localparam int unsigned AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [fsr_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [fsr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic [fsr_pkg::IDX_W-1:0]  read_index_i,
  output logic                            we_o,
  output logic      [AW-1:0]              waddr_o,
  output logic      [fsr_pkg::BYTE_W-1:0] wdata_o,
  output logic                            re_o,
  output logic      [AW-1:0]              raddr_o,
  output fsr_pkg::result_t                res_o
);
  import fsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               is_line, is_read, is_drop;
  logic               is_start, is_end, is_esc;
  logic               keep;
  logic               full;
  logic [CMP_W-1:0]   idx_ext, cnt_ext;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign is_line  = accept_i && (cmd_i == CMD_LINE);
  assign is_read  = accept_i && (cmd_i == CMD_READ);
  assign is_drop  = accept_i && (cmd_i == CMD_DROP);
  assign is_start = (rx_byte_i == BYTE_START);
  assign is_end   = (rx_byte_i == BYTE_END);
  assign is_esc   = (rx_byte_i == BYTE_ESCAPE);
  assign full     = (count_q == CNT_W'(FRAME_CAPACITY));

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (is_drop) begin
      phase_d = PH_IDLE;
    end else if (is_line) begin
      case (phase_q)
        PH_IDLE: begin
          if (is_start) phase_d = PH_IN;
        end
        PH_IN: begin
          if (is_end) begin
            phase_d = PH_DONE;
          end else if (is_esc) begin
            phase_d = PH_ESC;
          end
        end
        PH_ESC: begin
          if (is_end) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_IN;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // count and store write
  always_comb begin
    count_d = count_q;
    keep    = 1'b0;
    wdata_o = rx_byte_i;
    if (is_drop) begin
      count_d = '0;
    end else if (is_line) begin
      case (phase_q)
        PH_IDLE: begin
          if (is_start) count_d = '0;
        end
        PH_IN: begin
          if (is_start) begin
            count_d = '0;
          end else if (!is_end && !is_esc) begin
            keep = 1'b1;
          end
        end
        PH_ESC: begin
          if (is_start) begin
            count_d = '0;
          end else if (!is_end) begin
            keep    = 1'b1;
            wdata_o = rx_byte_i ^ ESCAPE_XOR;
          end
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
    // bytes past capacity are dropped
    we_o = keep && !full;
    if (we_o) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  assign waddr_o = count_q[AW-1:0];

  assign idx_ext = CMP_W'(read_index_i);
  assign cnt_ext = CMP_W'(count_q);
  assign re_o    = is_read;
  assign raddr_o = idx_ext[AW-1:0];

  assign len_ext = (CNT_W+LEN_W)'(count_d);

  always_comb begin
    res_o.frame_ready  = (phase_d == PH_DONE);
    res_o.frame_length = len_ext[LEN_W-1:0];
    // count never exceeds capacity, so this also bounds the address
    res_o.hit          = is_read && (idx_ext < cnt_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fsr_out.sv
// ----------------------------------------------------------------------------
// fsr_out
// handshake, read wait stage and output register
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_out (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  output logic                            accept_o,
  input  wire fsr_pkg::result_t           res_i,
  input  wire logic [fsr_pkg::BYTE_W-1:0] rdata_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            frame_ready_o,
  output logic      [fsr_pkg::LEN_W-1:0]  frame_length_o,
  output logic      [fsr_pkg::BYTE_W-1:0] read_data_o
);
  import fsr_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  result_t           s1_res_q;
  logic              out_valid_q, out_valid_d;
  logic              out_ready_q;
  logic [LEN_W-1:0]  out_length_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              s1_adv;

  // the wait stage moves on whenever the output register is free or drains
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept_o   = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = accept_o || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_res_q <= res_i;
    end
  end

  // store data is held until the next read, which only comes with a new accept
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ready_q  <= s1_res_q.frame_ready;
      out_length_q <= s1_res_q.frame_length;
      out_data_q   <= s1_res_q.hit ? rdata_i : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ready_o  = out_ready_q;
  assign frame_length_o = out_length_q;
  assign read_data_o    = out_data_q;

endmodule

`default_nettype wire

// File: rtl/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// deframes a flag delimited, escape stuffed byte stream into a frame store
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with cmd_i, rx_byte_i, read_index_i;
//   a word is taken at a rising edge with in_valid_i high and in_stall_o low.
//   cmd line byte feeds the deframer, cmd read returns a stored byte, cmd drop
//   releases the held frame and returns to idle.
//   output channel: out_valid_o / out_stall_i with frame_ready_o,
//   frame_length_o and read_data_o; exactly one result word per input word.
//   path: after its word is taken, a result passes the synchronous store read
//   and the wait stage, then the output register.
//   throughput: one word per cycle while in_stall_o is low; phase and count
//   live in flops, and each word makes at most one store write or one read.
//   stall: a wait stage plus the output register hold two results, so one
//   more word is taken while a result sits stalled; then in_stall_o rises.
//   reset: phase idle, count zero, both stages empty; store contents are
//   left as they are and are only returned below the current count.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_receiver #(
  parameter int unsigned FRAME_CAPACITY = fsr_pkg::FRAME_CAPACITY_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [fsr_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [fsr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic [fsr_pkg::IDX_W-1:0]  read_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            frame_ready_o,
  output logic      [fsr_pkg::LEN_W-1:0]  frame_length_o,
  output logic      [fsr_pkg::BYTE_W-1:0] read_data_o
);
  import fsr_pkg::*;

  localparam int unsigned AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;

  logic              accept;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] wdata, rdata;
  result_t           res;

  fsr_ctrl #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .read_index_i(read_index_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .res_o       (res)
  );

  fsr_store #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  fsr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .accept_o      (accept),
    .res_i         (res),
    .rdata_i       (rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_ready_o (frame_ready_o),
    .frame_length_o(frame_length_o),
    .read_data_o   (read_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/fsr_checker.sv
// ----------------------------------------------------------------------------
// fsr_checker
// port level checks of the byte stuffed frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fsr_checker #(
  parameter int unsigned FRAME_CAPACITY = fsr_pkg::FRAME_CAPACITY_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_stall_i,
  input wire logic                       frame_ready_i,
  input wire logic [fsr_pkg::LEN_W-1:0]  frame_length_i,
  input wire logic [fsr_pkg::BYTE_W-1:0] read_data_i
);
  import fsr_pkg::*;

  localparam bit WIDE_CAP = (FRAME_CAPACITY >= 256);

  // a stalled result stays offered
  `FSR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)

  // input only backs up when a result is waiting on a stalled receiver
  `FSR_ASSERT_ALWAYS(a_stall_cause, clk_i, in_stall_i |-> (out_valid_i && out_stall_i))

  // a word taken while no result is offered passes the wait stage and the output register
  `FSR_ASSERT(a_latency, clk_i, rst_ni, !out_valid_i && !in_stall_i && in_valid_i |=> ##1 out_valid_i)

  // stored data can only come back from a frame that holds bytes
  `FSR_ASSERT(a_data_len, clk_i, rst_ni, out_valid_i && (|read_data_i) |-> (|frame_length_i) || WIDE_CAP)

endmodule

bind byte_stuffed_frame_receiver fsr_checker #(
  .FRAME_CAPACITY(FRAME_CAPACITY)
) u_fsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_ready_i (frame_ready_o),
  .frame_length_i(frame_length_o),
  .read_data_i   (read_data_o)
);

`default_nettype wire
